[src/assert_macros.svh]
// Assertion macros shared by the stopwatch RTL.
// Needs a clock named clk and an active high reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define LSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define LSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lsw_pkg.sv]
// Shared types for the lap stopwatch: command codes and the stage words.
// No dependencies.
`default_nettype none

package lsw_pkg;

  // Command codes carried on the cmd field
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_PAUSE    = 3'd1,
    CMD_RESUME   = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_RESET    = 3'd4,
    CMD_ADD_LAP  = 3'd5,
    CMD_READ_LAP = 3'd6
  } cmd_t;

  // Word from the command stage to the time split pipeline
  typedef struct packed {
    logic [1:0]  run_state;
    logic [31:0] elapsed;
    logic [4:0]  lap_total;
    logic        lap_valid;
    logic        lap_last;
    logic        lap_live;
    logic [31:0] live_len;
    logic [31:0] lap_off;
    logic [31:0] lap_len;
  } lsw_stage_t;

  // Finished result word
  typedef struct packed {
    logic [1:0]  run_state;
    logic [31:0] elapsed_ms;
    logic [16:0] elapsed_minutes;
    logic [5:0]  elapsed_seconds;
    logic [9:0]  elapsed_millis;
    logic [4:0]  lap_total;
    logic        lap_valid;
    logic [31:0] lap_offset_ms;
    logic [31:0] lap_length_ms;
  } lsw_result_t;

endpackage

`default_nettype wire

[src/lsw_ctrl.sv]
// Command stage: run state, time stamps, lap count and the lap tables.
// Uses lsw_pkg and assert_macros.svh; feeds lsw_split with one stage word per command.
`default_nettype none
`include "assert_macros.svh"

module lsw_ctrl import lsw_pkg::*; #(
  parameter int LAP_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic [3:0]  lap_index,
  input  logic        s1_ready,
  output logic        s1_valid,
  output lsw_stage_t  s1
);

  localparam int CW   = $clog2(LAP_DEPTH + 1);
  localparam int AW   = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_RUNNING = 2'd1,
    PH_PAUSED  = 2'd2
  } phase_t;

  phase_t          phase, phase_next;
  // origin is the start stamp plus the total paused time
  logic [31:0]     origin, origin_next;
  logic [31:0]     pause_stamp, pause_stamp_next;
  logic [31:0]     lap_begin, lap_begin_next;
  logic [CW-1:0]   lap_count, lap_count_next;

  logic            ready1, accept;
  logic            starting, resuming, pausing, adding;
  logic [31:0]     gap, diff_now, diff_pause, since_lap, elapsed_next;
  logic [CMPW-1:0] idx_ext, cnt_ext;
  logic            rd_valid, rd_last, rd_live;

  // Stage one holding registers
  logic [1:0]      s1_phase;
  logic [31:0]     s1_elapsed;
  logic [4:0]      s1_total;
  logic            s1_lap_valid, s1_lap_last, s1_lap_live;
  logic [31:0]     s1_live_len;

  // Lap tables and their registered read data
  logic [31:0]     lap_offsets [LAP_DEPTH];
  logic [31:0]     lap_lengths [LAP_DEPTH];
  logic [31:0]     off_rd, len_rd;

  // Take a word when stage one is empty or draining
  assign ready1   = !s1_valid || s1_ready;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;

  // Decode the command against the current state
  always_comb begin
    gap        = now_ms - pause_stamp;
    diff_now   = now_ms - origin;
    diff_pause = pause_stamp - origin;
    since_lap  = now_ms - lap_begin;

    starting = (cmd == CMD_START) && (phase == PH_STOPPED);
    resuming = ((cmd == CMD_START) || (cmd == CMD_RESUME)) && (phase == PH_PAUSED);
    pausing  = (cmd == CMD_PAUSE) && (phase == PH_RUNNING);
    adding   = (cmd == CMD_ADD_LAP) && (phase == PH_RUNNING) &&
               (lap_count < CW'(LAP_DEPTH));

    idx_ext  = CMPW'(lap_index);
    cnt_ext  = CMPW'(lap_count);
    rd_valid = (cmd == CMD_READ_LAP) && (idx_ext < cnt_ext);
    rd_last  = (idx_ext == CMPW'(cnt_ext - 1'b1));
    rd_live  = (phase == PH_RUNNING) && (lap_begin != '0);
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    origin_next      = origin;
    pause_stamp_next = pause_stamp;
    lap_begin_next   = lap_begin;
    lap_count_next   = lap_count;
    unique case (cmd_t'(cmd))
      CMD_START, CMD_RESUME: begin
        if (starting) begin
          origin_next    = now_ms;
          lap_begin_next = now_ms;
          lap_count_next = '0;
          phase_next     = PH_RUNNING;
        end else if (resuming) begin
          // push the origin and the lap start past the paused interval
          origin_next = origin + gap;
          if (lap_begin != '0) begin
            lap_begin_next = lap_begin + gap;
          end
          phase_next = PH_RUNNING;
        end
      end
      CMD_PAUSE: begin
        if (pausing) begin
          pause_stamp_next = now_ms;
          phase_next       = PH_PAUSED;
        end
      end
      CMD_STOP: begin
        phase_next       = PH_STOPPED;
        origin_next      = '0;
        pause_stamp_next = '0;
        lap_begin_next   = '0;
      end
      CMD_RESET: begin
        phase_next       = PH_STOPPED;
        origin_next      = '0;
        pause_stamp_next = '0;
        lap_begin_next   = '0;
        lap_count_next   = '0;
      end
      CMD_ADD_LAP: begin
        if (adding) begin
          lap_begin_next = now_ms;
          lap_count_next = CW'(lap_count + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Active time after the command, one subtract from the current origin
  always_comb begin
    priority if ((phase_next == PH_STOPPED) || starting) begin
      elapsed_next = '0;
    end else if (resuming) begin
      elapsed_next = diff_pause;
    end else if ((phase_next == PH_RUNNING) || pausing) begin
      elapsed_next = diff_now;
    end else begin
      elapsed_next = diff_pause;
    end
  end

  // Hold state and the stage one word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STOPPED;
      origin      <= '0;
      pause_stamp <= '0;
      lap_begin   <= '0;
      lap_count   <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        origin       <= origin_next;
        pause_stamp  <= pause_stamp_next;
        lap_begin    <= lap_begin_next;
        lap_count    <= lap_count_next;
        s1_phase     <= phase_next;
        s1_elapsed   <= elapsed_next;
        s1_total     <= 5'(lap_count_next);
        s1_lap_valid <= rd_valid;
        s1_lap_last  <= rd_last;
        s1_lap_live  <= rd_live;
        s1_live_len  <= since_lap;
      end
      if (ready1) begin
        s1_valid <= in_valid;
      end
    end
  end

  // Lap tables: close the previous lap, open the new one, read one entry
  always_ff @(posedge clk) begin
    if (accept) begin
      if (adding) begin
        lap_offsets[AW'(lap_count)] <= diff_now;
        if (lap_count != '0) begin
          lap_lengths[AW'(lap_count - 1'b1)] <= since_lap;
        end
      end
      off_rd <= lap_offsets[AW'(lap_index)];
      len_rd <= lap_lengths[AW'(lap_index)];
    end
  end

  always_comb begin
    s1.run_state = s1_phase;
    s1.elapsed   = s1_elapsed;
    s1.lap_total = s1_total;
    s1.lap_valid = s1_lap_valid;
    s1.lap_last  = s1_lap_last;
    s1.lap_live  = s1_lap_live;
    s1.live_len  = s1_live_len;
    s1.lap_off   = off_rd;
    s1.lap_len   = len_rd;
  end

  `LSW_ASSERT_NOW(a_count_bound, 1'b1, lap_count <= CW'(LAP_DEPTH), "lap count above table depth")
  `LSW_ASSERT_NEXT(a_stop_clears, accept && (cmd == CMD_STOP), (phase == PH_STOPPED) && (origin == '0), "stop left the watch running")
  `LSW_ASSERT_NEXT(a_reset_laps, accept && (cmd == CMD_RESET), lap_count == '0, "reset kept laps")

endmodule

`default_nettype wire

[src/lsw_split.sv]
// Time split pipeline: lap field selection and minutes, seconds, millis split.
// Uses lsw_pkg and assert_macros.svh; fed by lsw_ctrl.
`default_nettype none
`include "assert_macros.svh"

module lsw_split import lsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s1_valid,
  input  lsw_stage_t  s1,
  output logic        s1_ready,
  input  logic        out_stall,
  output logic        out_valid,
  output lsw_result_t res
);

  // Reciprocals: ceil(2^38 / 1000) is exact for 32-bit values,
  // ceil(2^29 / 60) is exact for quotients below 2^23.
  localparam logic [28:0] RECIP_MS    = 29'd274877907;
  localparam int          SHIFT_MS    = 38;
  localparam logic [23:0] RECIP_MIN   = 24'd8947849;
  localparam int          SHIFT_MIN   = 29;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  logic        ready2, ready3, ready4;
  logic [60:0] p_ms;
  logic [46:0] p_min;

  logic        v2;
  logic [1:0]  s2_state;
  logic [31:0] s2_elapsed;
  logic [4:0]  s2_total;
  logic        s2_lap_valid;
  logic [31:0] s2_off, s2_len;
  logic [22:0] s2_q;

  logic        v3;
  logic [1:0]  s3_state;
  logic [31:0] s3_elapsed;
  logic [4:0]  s3_total;
  logic        s3_lap_valid;
  logic [31:0] s3_off, s3_len;
  logic [9:0]  s3_millis;
  logic [16:0] s3_min;
  logic [5:0]  s3_q6;

  // Each stage loads when empty or when the next one moves
  assign ready4   = !out_valid || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign s1_ready = ready2;

  assign p_ms  = s1.elapsed * RECIP_MS;
  assign p_min = s2_q * RECIP_MIN;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready2) v2 <= s1_valid;
      if (ready3) v3 <= v2;
      if (ready4) out_valid <= v3;
    end
  end

  // Stage two: whole seconds, lap field select
  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_state     <= s1.run_state;
      s2_elapsed   <= s1.elapsed;
      s2_total     <= s1.lap_total;
      s2_lap_valid <= s1.lap_valid;
      s2_q         <= p_ms[SHIFT_MS +: 23];
      s2_off       <= s1.lap_valid ? s1.lap_off : '0;
      if (!s1.lap_valid) begin
        s2_len <= '0;
      end else if (s1.lap_last) begin
        s2_len <= s1.lap_live ? s1.live_len : '0;
      end else begin
        s2_len <= s1.lap_len;
      end
    end
  end

  // Stage three: millis remainder and whole minutes
  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      s3_state     <= s2_state;
      s3_elapsed   <= s2_elapsed;
      s3_total     <= s2_total;
      s3_lap_valid <= s2_lap_valid;
      s3_off       <= s2_off;
      s3_len       <= s2_len;
      s3_millis    <= s2_elapsed[9:0] - 10'(s2_q[9:0] * MS_PER_SEC);
      s3_min       <= p_min[SHIFT_MIN +: 17];
      s3_q6        <= s2_q[5:0];
    end
  end

  // Output register: seconds remainder
  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      res.run_state       <= s3_state;
      res.elapsed_ms      <= s3_elapsed;
      res.elapsed_minutes <= s3_min;
      res.elapsed_seconds <= s3_q6 - 6'(s3_min[5:0] * SEC_PER_MIN);
      res.elapsed_millis  <= s3_millis;
      res.lap_total       <= s3_total;
      res.lap_valid       <= s3_lap_valid;
      res.lap_offset_ms   <= s3_off;
      res.lap_length_ms   <= s3_len;
    end
  end

  `LSW_ASSERT_NOW(a_split_range, out_valid, (res.elapsed_millis < MS_PER_SEC) && (res.elapsed_seconds < SEC_PER_MIN), "split field out of range")
  `LSW_ASSERT_NOW(a_split_sum, out_valid, res.elapsed_ms == 32'(res.elapsed_minutes) * 32'd60000 + 32'(res.elapsed_seconds) * 32'd1000 + 32'(res.elapsed_millis), "split does not add up")
  `LSW_ASSERT_NOW(a_lap_zero, out_valid && !res.lap_valid, (res.lap_offset_ms == '0) && (res.lap_length_ms == '0), "lap fields set on invalid read")

endmodule

`default_nettype wire

[src/lap_stopwatch_unit.sv]
// Top level of the lap stopwatch: command stage plus time split pipeline.
// Uses lsw_pkg, lsw_ctrl and lsw_split.
`default_nettype none

// Pausable millisecond stopwatch with a table of LAP_DEPTH laps. Every command
// word carries the current timestamp and yields exactly one result word with the
// run state, the active time and its minutes/seconds/millis split, the lap count
// and, for a read lap command, the chosen lap. One command word is taken every
// clock while in_stall is low; its result passes the state and lap table update
// register, then three pipeline stages that split the time by
// reciprocal multiplication (divide by 1000, then by 60). Lap table entries hold
// no reset value, which is fine because only laps already recorded can be read;
// there is no clearing pass after reset.
module lap_stopwatch_unit import lsw_pkg::*; #(
  parameter int LAP_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] now_ms,
  input  logic [3:0]  lap_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  run_state,
  output logic [31:0] elapsed_ms,
  output logic [16:0] elapsed_minutes,
  output logic [5:0]  elapsed_seconds,
  output logic [9:0]  elapsed_millis,
  output logic [4:0]  lap_total,
  output logic        lap_valid,
  output logic [31:0] lap_offset_ms,
  output logic [31:0] lap_length_ms
);

  logic        s1_valid, s1_ready;
  lsw_stage_t  s1;
  lsw_result_t res;

  lsw_ctrl #(
    .LAP_DEPTH (LAP_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .now_ms    (now_ms),
    .lap_index (lap_index),
    .s1_ready  (s1_ready),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  lsw_split u_split (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  // Unpack the result word onto the field ports
  assign run_state       = res.run_state;
  assign elapsed_ms      = res.elapsed_ms;
  assign elapsed_minutes = res.elapsed_minutes;
  assign elapsed_seconds = res.elapsed_seconds;
  assign elapsed_millis  = res.elapsed_millis;
  assign lap_total       = res.lap_total;
  assign lap_valid       = res.lap_valid;
  assign lap_offset_ms   = res.lap_offset_ms;
  assign lap_length_ms   = res.lap_length_ms;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for lap_stopwatch_unit: directed and random stopwatch command words,
// each result word predicted locally and checked field by field.
// Depends on lsw_pkg and the lap_stopwatch_unit RTL.
module testbench;
  import lsw_pkg::*;

  localparam int LAP_DEPTH = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    SW_STOPPED = 2'd0,
    SW_RUNNING = 2'd1,
    SW_PAUSED  = 2'd2
  } sw_phase_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] stamp;
    logic [3:0]  idx;
  } sw_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_START;
  logic [31:0] now_ms = '0;
  logic [3:0]  lap_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  run_state;
  logic [31:0] elapsed_ms;
  logic [16:0] elapsed_minutes;
  logic [5:0]  elapsed_seconds;
  logic [9:0]  elapsed_millis;
  logic [4:0]  lap_total;
  logic        lap_valid;
  logic [31:0] lap_offset_ms;
  logic [31:0] lap_length_ms;

  // Predicted stopwatch state
  sw_phase_t   sw_phase;
  logic [31:0] run_begin;
  logic [31:0] paused_total;
  logic [31:0] paused_at;
  logic [31:0] lap_begin;
  logic [4:0]  laps_done;
  logic [31:0] lap_offset_tbl [LAP_DEPTH];
  logic [31:0] lap_length_tbl [LAP_DEPTH];

  sw_cmd_t     pending_cmds [$];
  lsw_result_t expected_results [$];

  int cycle_count = 0;
  int cmds_taken = 0;
  int items_total = 0;
  int mismatch_count = 0;
  int send_wait = 0;
  int take_wait = 0;
  bit calm_send = 1'b0;
  bit calm_take = 1'b0;
  bit cmd_taken = 1'b0;
  bit res_taken = 1'b0;

  lap_stopwatch_unit #(.LAP_DEPTH(LAP_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .now_ms(now_ms),
    .lap_index(lap_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .run_state(run_state),
    .elapsed_ms(elapsed_ms),
    .elapsed_minutes(elapsed_minutes),
    .elapsed_seconds(elapsed_seconds),
    .elapsed_millis(elapsed_millis),
    .lap_total(lap_total),
    .lap_valid(lap_valid),
    .lap_offset_ms(lap_offset_ms),
    .lap_length_ms(lap_length_ms)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold the paused interval into the total and shift the lap stamp if set
  function automatic void resume_clock(logic [31:0] stamp);
    logic [31:0] gap;
    if (sw_phase == SW_PAUSED) begin
      gap = stamp - paused_at;
      paused_total += gap;
      if (lap_begin != '0) lap_begin += gap;
      sw_phase = SW_RUNNING;
    end
  endfunction

  function automatic void stop_clock();
    sw_phase = SW_STOPPED;
    run_begin = '0;
    paused_total = '0;
    paused_at = '0;
    lap_begin = '0;
  endfunction

  // Apply one command word to the predicted state and form its result word
  function automatic lsw_result_t stopwatch_step(sw_cmd_t c);
    lsw_result_t r;
    logic [31:0] el;
    r = '0;
    el = '0;
    case (c.op)
      CMD_START: begin
        if (sw_phase == SW_STOPPED) begin
          run_begin = c.stamp;
          paused_total = '0;
          laps_done = '0;
          lap_begin = c.stamp;
          sw_phase = SW_RUNNING;
        end else begin
          resume_clock(c.stamp);
        end
      end
      CMD_PAUSE: begin
        if (sw_phase == SW_RUNNING) begin
          paused_at = c.stamp;
          sw_phase = SW_PAUSED;
        end
      end
      CMD_RESUME: resume_clock(c.stamp);
      CMD_STOP: stop_clock();
      CMD_RESET: begin
        stop_clock();
        laps_done = '0;
      end
      CMD_ADD_LAP: begin
        if (sw_phase == SW_RUNNING && laps_done < LAP_DEPTH) begin
          if (laps_done != '0) lap_length_tbl[laps_done - 1] = c.stamp - lap_begin;
          lap_offset_tbl[laps_done] = c.stamp - run_begin - paused_total;
          lap_length_tbl[laps_done] = '0;
          lap_begin = c.stamp;
          laps_done++;
        end
      end
      CMD_READ_LAP: begin
        if ({1'b0, c.idx} < laps_done) begin
          r.lap_valid = 1'b1;
          r.lap_offset_ms = lap_offset_tbl[c.idx];
          r.lap_length_ms = lap_length_tbl[c.idx];
          // last lap shows its live length while running
          if ({1'b0, c.idx} == laps_done - 5'd1 && sw_phase == SW_RUNNING && lap_begin != '0)
            r.lap_length_ms = c.stamp - lap_begin;
        end
      end
      default: ;
    endcase
    if (sw_phase == SW_PAUSED) el = paused_at - run_begin - paused_total;
    else if (sw_phase == SW_RUNNING) el = c.stamp - run_begin - paused_total;
    r.run_state = sw_phase;
    r.elapsed_ms = el;
    r.elapsed_minutes = 17'(el / 32'd60000);
    r.elapsed_seconds = 6'((el / 32'd1000) % 32'd60);
    r.elapsed_millis = 10'(el % 32'd1000);
    r.lap_total = laps_done;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
  endtask

  task automatic queue_cmd(logic [2:0] op, logic [31:0] stamp, logic [3:0] idx);
    sw_cmd_t c;
    c.op = op;
    c.stamp = stamp;
    c.idx = idx;
    pending_cmds.push_back(c);
  endtask

  // Sample both handshakes, predict taken commands, check taken results
  always @(posedge clk) begin : monitor
    lsw_result_t want;
    lsw_result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      cmd_taken = !rst && in_valid && !in_stall;
      res_taken = !rst && out_valid && !out_stall;
      if (cmd_taken) begin
        expected_results.push_back(stopwatch_step({cmd, now_ms, lap_index}));
        cmds_taken++;
      end
      if (res_taken) begin
        got.run_state = run_state;
        got.elapsed_ms = elapsed_ms;
        got.elapsed_minutes = elapsed_minutes;
        got.elapsed_seconds = elapsed_seconds;
        got.elapsed_millis = elapsed_millis;
        got.lap_total = lap_total;
        got.lap_valid = lap_valid;
        got.lap_offset_ms = lap_offset_ms;
        got.lap_length_ms = lap_length_ms;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result word, run_state", '0, got.run_state);
        end else begin
          want = expected_results.pop_front();
          if (got.run_state != want.run_state)
            note_mismatch("run_state", want.run_state, got.run_state);
          if (got.elapsed_ms != want.elapsed_ms)
            note_mismatch("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
          if (got.elapsed_minutes != want.elapsed_minutes)
            note_mismatch("elapsed_minutes", want.elapsed_minutes, got.elapsed_minutes);
          if (got.elapsed_seconds != want.elapsed_seconds)
            note_mismatch("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
          if (got.elapsed_millis != want.elapsed_millis)
            note_mismatch("elapsed_millis", want.elapsed_millis, got.elapsed_millis);
          if (got.lap_total != want.lap_total)
            note_mismatch("lap_total", want.lap_total, got.lap_total);
          if (got.lap_valid != want.lap_valid)
            note_mismatch("lap_valid", want.lap_valid, got.lap_valid);
          if (got.lap_offset_ms != want.lap_offset_ms)
            note_mismatch("lap_offset_ms", want.lap_offset_ms, got.lap_offset_ms);
          if (got.lap_length_ms != want.lap_length_ms)
            note_mismatch("lap_length_ms", want.lap_length_ms, got.lap_length_ms);
        end
      end
    end
  end

  // Present command words, with a random gap after each one
  always @(negedge clk) begin : driver
    sw_cmd_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !cmd_taken) begin
      // hold the stalled word
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait--;
    end else if (pending_cmds.size() > 0) begin
      item = pending_cmds.pop_front();
      cmd <= item.op;
      now_ms <= item.stamp;
      lap_index <= item.idx;
      in_valid <= 1'b1;
      send_wait = calm_send ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result side for a random number of cycles after each word
  always @(negedge clk) begin : receiver
    if (res_taken) begin
      take_wait = calm_take ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 39) == 0) calm_take = !calm_take;
    end
    if (take_wait > 0) begin
      out_stall <= 1'b1;
      take_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    int pick;
    int session_len;
    int produced;
    stop_clock();
    laps_done = '0;
    send_wait = $urandom_range(0, 3);
    take_wait = $urandom_range(0, 3);

    // Idle stopwatch: empty table, unused code, ignored commands
    queue_cmd(CMD_READ_LAP, 32'hFFFF_FFFF, 4'd15);
    queue_cmd(CMD_UNUSED, 32'd7, 4'd0);
    queue_cmd(CMD_PAUSE, 32'd10, 4'd0);
    queue_cmd(CMD_RESUME, 32'd20, 4'd0);
    queue_cmd(CMD_ADD_LAP, 32'd30, 4'd0);
    // Start at zero so the lap stamp stays clear across a resume
    queue_cmd(CMD_START, 32'd0, 4'd0);
    queue_cmd(CMD_PAUSE, 32'd50, 4'd0);
    queue_cmd(CMD_RESUME, 32'd80, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'd90, 4'd0);
    queue_cmd(CMD_ADD_LAP, 32'd100, 4'd0);
    // Start while running, pause twice, start while paused
    queue_cmd(CMD_START, 32'd110, 4'd0);
    queue_cmd(CMD_PAUSE, 32'd150, 4'd0);
    queue_cmd(CMD_PAUSE, 32'd160, 4'd0);
    queue_cmd(CMD_START, 32'd170, 4'd0);
    queue_cmd(CMD_ADD_LAP, 32'd200, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'd260, 4'd1);
    queue_cmd(CMD_READ_LAP, 32'd270, 4'd0);
    // Stop keeps the laps, the last one reads as closed
    queue_cmd(CMD_STOP, 32'd300, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'd310, 4'd1);
    // Run across the timestamp wrap
    queue_cmd(CMD_START, 32'hFFFF_FF00, 4'd0);
    queue_cmd(CMD_ADD_LAP, 32'h0000_0100, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'h0000_0200, 4'd0);
    queue_cmd(CMD_RESET, 32'd5, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'd6, 4'd0);
    // Largest elapsed time
    queue_cmd(CMD_START, 32'd1, 4'd0);
    queue_cmd(CMD_READ_LAP, 32'd0, 4'd15);
    queue_cmd(CMD_STOP, 32'd2, 4'd0);

    // Random sessions: start, a burst of activity, then stop or reset
    produced = 0;
    t = $urandom;
    while (produced < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) t = '0;
      else if ($urandom_range(0, 7) == 0) t = 32'hFFFF_F000 + $urandom_range(0, 4095);
      queue_cmd(CMD_START, t, 4'($urandom));
      session_len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70)
                                                : $urandom_range(4, 25);
      repeat (session_len) begin
        t += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3000);
        pick = $urandom_range(0, 99);
        if (pick < 8) queue_cmd(3'($urandom_range(0, 7)), $urandom, 4'($urandom));
        else if (pick < 40) queue_cmd(CMD_ADD_LAP, t, 4'($urandom));
        else if (pick < 65) queue_cmd(CMD_READ_LAP, t, 4'($urandom_range(0, 15)));
        else if (pick < 75) queue_cmd(CMD_PAUSE, t, 4'($urandom));
        else if (pick < 87) queue_cmd(CMD_RESUME, t, 4'($urandom));
        else queue_cmd(CMD_START, t, 4'($urandom));
      end
      t += $urandom_range(0, 3000);
      queue_cmd($urandom_range(0, 1) ? CMD_STOP : CMD_RESET, t, 4'($urandom));
      produced += session_len + 2;
    end
    items_total = pending_cmds.size();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Wait for every word to go in and every result to come back
    while (cmds_taken < items_total || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/lsw_pkg.sv
src/lsw_ctrl.sv
src/lsw_split.sv
src/lap_stopwatch_unit.sv
tb/testbench.sv
